>>> rtl/core/bdo_pkg.sv
package bdo_pkg;

    // Bus operation codes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // Target regions
    typedef enum logic [3:0] {
        T_NONE   = 4'd0,
        T_HRAM   = 4'd1,
        T_WRAM0  = 4'd2,
        T_WRAM1  = 4'd3,
        T_ECHO   = 4'd4,
        T_UNUSED = 4'd5,
        T_OAM    = 4'd6,
        T_VRAM   = 4'd7,
        T_CART   = 4'd8,
        T_BOOT   = 4'd9,
        T_IO     = 4'd10,
        T_IF     = 4'd11,
        T_IE     = 4'd12
    } target_t;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_ROM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CART     = 1'd1;

    localparam logic [7:0]  DMA_START = 8'hA2;
    localparam logic [7:0]  OAM_LEN   = 8'hA0;
    localparam logic [6:0]  DMA_REG   = 7'h46;
    localparam logic [7:0]  OPEN_BUS  = 8'hFF;

    localparam logic [15:0] ADDR_IE     = 16'hFFFF;
    localparam logic [15:0] ADDR_HRAM   = 16'hFF80;
    localparam logic [15:0] ADDR_IF     = 16'hFF0F;
    localparam logic [15:0] ADDR_IO     = 16'hFF00;
    localparam logic [15:0] ADDR_UNUSED = 16'hFEA0;
    localparam logic [15:0] ADDR_OAM    = 16'hFE00;
    localparam logic [15:0] ADDR_ECHO   = 16'hE000;
    localparam logic [15:0] ADDR_WRAM1  = 16'hD000;
    localparam logic [15:0] ADDR_WRAM0  = 16'hC000;
    localparam logic [15:0] ADDR_XRAM   = 16'hA000;
    localparam logic [15:0] ADDR_VRAM   = 16'h8000;
    localparam logic [15:0] ADDR_BOOTEND = 16'h0100;

    // Classified item handed from front to back.
    // raw = 1: back decodes addr as a plain memory read.
    // raw = 0: target/addr (as offset) and the rest are final.
    typedef struct packed {
        logic        raw;
        target_t     target;
        logic [15:0] addr;
        logic        we;
        logic [7:0]  sbyte;
        logic        dvalid;
        logic [7:0]  dbyte;
        logic        copy;
        logic [7:0]  oidx;
    } cmd_t;

    typedef struct packed {
        logic boot_rom_mapped;
        logic cartridge_present;
    } cfg_t;

endpackage

>>> rtl/core/bus_decoder_with_oam_dma_top.sv
// Memory map decoder of a handheld console with the object-attribute DMA
// sequencer. Each input item is a CPU read (opcode 0), a CPU write (1) or one
// DMA clock tick (2). Reads and writes always give one result item: the target
// region and its local offset, or a byte answered directly (open bus 0xFF or
// the DMA page register). A write of IO register 0x46 starts a transfer: two
// startup ticks, then 160 ticks that each give a result with dma_copy set,
// naming the source location and the OAM index that receives it. Idle and
// startup ticks give no result, nor does opcode 3. The block takes one item
// every cycle while s_ready is high; a result goes from the front's
// classifier through a small queue (QUEUE_DEPTH items) and the output register
// to the m_ port, where it waits while m_ready is low. s_ready drops only
// while the queue is full. The two configuration registers (index 0 boot ROM
// mapped, index 1 cartridge present, bit 0 of cfg_data) reset to 1 and are to
// be written only while no item is in flight; cfg_ready is always high.
module bus_decoder_with_oam_dma_top
    import bdo_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // input item channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic [15:0]           s_address,
    input  logic [7:0]            s_write_data,

    // result item channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_target,
    output logic [15:0]           m_offset,
    output logic                  m_write_enable,
    output logic [7:0]            m_store_byte,
    output logic                  m_direct_valid,
    output logic [7:0]            m_direct_byte,
    output logic                  m_dma_copy,
    output logic [7:0]            m_oam_index
);

    cfg_t cfg_reg;
    logic q_full, q_not_empty, q_pop, push, accept;
    cmd_t push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.boot_rom_mapped   <= 1'b1;
            cfg_reg.cartridge_present <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BOOT_ROM: cfg_reg.boot_rom_mapped   <= cfg_data[0];
                CFG_CART:     cfg_reg.cartridge_present <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // front side takes an item whenever the queue has room
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    bdo_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .accept     (accept),
        .opcode     (s_opcode),
        .address    (s_address),
        .write_data (s_write_data),
        .push       (push),
        .cmd        (push_cmd)
    );

    bdo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_cmd)
    );

    // back side: final decode and output register
    bdo_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_not_empty),
        .q_data         (pop_cmd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_target       (m_target),
        .m_offset       (m_offset),
        .m_write_enable (m_write_enable),
        .m_store_byte   (m_store_byte),
        .m_direct_valid (m_direct_valid),
        .m_direct_byte  (m_direct_byte),
        .m_dma_copy     (m_dma_copy),
        .m_oam_index    (m_oam_index)
    );

endmodule

>>> rtl/core/bdo_front.sv
module bdo_front
    import bdo_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        accept,
    input  logic [1:0]  opcode,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        push,
    output cmd_t        cmd
);

    logic [7:0]  cd_reg, cd_next;
    logic [7:0]  page_reg, page_next;
    logic [15:0] src_reg, src_next;
    logic        has_result;
    logic [7:0]  idx;
    logic        a_vram, src_vram;
    logic        dma_busy;

    assign a_vram   = (address[15:13] == 3'b100);
    assign src_vram = (src_reg[15:13] == 3'b100);
    assign dma_busy = (cd_reg != 8'd0) && (cd_reg <= OAM_LEN);
    assign idx      = OAM_LEN - cd_reg;

    always_comb begin
        cmd        = '0;
        has_result = 1'b1;
        cd_next    = cd_reg;
        page_next  = page_reg;
        src_next   = src_reg;
        case (op_t'(opcode))
            OP_READ: begin
                if (address == ADDR_IE) begin
                    cmd.target = T_IE;
                    cmd.addr   = 16'h00FF;
                end else if (address >= ADDR_HRAM) begin
                    cmd.target = T_HRAM;
                    cmd.addr   = address - ADDR_HRAM;
                end else if (address == ADDR_IF) begin
                    cmd.target = T_IF;
                    cmd.addr   = 16'h000F;
                end else if (address >= ADDR_IO) begin
                    if (address[6:0] == DMA_REG) begin
                        cmd.dvalid = 1'b1;
                        cmd.dbyte  = page_reg;
                    end else begin
                        cmd.target = T_IO;
                        cmd.addr   = {9'd0, address[6:0]};
                    end
                end else if (cd_reg != 8'd0) begin
                    // bus conflict with a running transfer
                    if (cd_reg <= OAM_LEN && address >= ADDR_OAM) begin
                        cmd.dvalid = 1'b1;
                        cmd.dbyte  = OPEN_BUS;
                    end else begin
                        cmd.raw  = 1'b1;
                        cmd.addr = (a_vram != src_vram) ? address : src_reg;
                    end
                end else if (address >= ADDR_UNUSED) begin
                    cmd.target = T_UNUSED;
                    cmd.addr   = address - ADDR_UNUSED;
                end else if (address >= ADDR_OAM) begin
                    cmd.target = T_OAM;
                    cmd.addr   = address - ADDR_OAM;
                end else begin
                    cmd.raw  = 1'b1;
                    cmd.addr = address;
                end
            end
            OP_WRITE: begin
                cmd.we    = 1'b1;
                cmd.sbyte = write_data;
                if (address == ADDR_IE) begin
                    cmd.target = T_IE;
                    cmd.addr   = 16'h00FF;
                end else if (address >= ADDR_HRAM) begin
                    cmd.target = T_HRAM;
                    cmd.addr   = address - ADDR_HRAM;
                end else if (address == ADDR_IF) begin
                    cmd.target = T_IF;
                    cmd.addr   = 16'h000F;
                end else if (address >= ADDR_IO) begin
                    if (address[6:0] == DMA_REG) begin
                        cmd = '0;
                        if (cd_reg < OAM_LEN) begin
                            page_next = write_data;
                            cd_next   = DMA_START;
                        end
                    end else begin
                        cmd.target = T_IO;
                        cmd.addr   = {9'd0, address[6:0]};
                    end
                end else if (dma_busy) begin
                    cmd = '0;
                end else if (address >= ADDR_UNUSED) begin
                    cmd        = '0;
                    cmd.target = T_UNUSED;
                    cmd.addr   = address - ADDR_UNUSED;
                end else if (address >= ADDR_OAM) begin
                    cmd.target = T_OAM;
                    cmd.addr   = address - ADDR_OAM;
                end else if (address >= ADDR_ECHO) begin
                    cmd.target = T_ECHO;
                    cmd.addr   = address - ADDR_ECHO;
                end else if (address >= ADDR_WRAM1) begin
                    cmd.target = T_WRAM1;
                    cmd.addr   = address - ADDR_WRAM1;
                end else if (address >= ADDR_WRAM0) begin
                    cmd.target = T_WRAM0;
                    cmd.addr   = address - ADDR_WRAM0;
                end else if (address >= ADDR_VRAM && address < ADDR_XRAM) begin
                    cmd.target = T_VRAM;
                    cmd.addr   = address - ADDR_VRAM;
                end else if (cfg.cartridge_present) begin
                    cmd.target = T_CART;
                    cmd.addr   = address;
                end else begin
                    cmd = '0;
                end
            end
            OP_TICK: begin
                if (cd_reg == 8'd0) begin
                    has_result = 1'b0;
                end else begin
                    cd_next = cd_reg - 8'd1;
                    if (cd_reg <= OAM_LEN) begin
                        src_next = {page_reg, idx};
                        cmd.raw  = 1'b1;
                        cmd.addr = {page_reg, idx};
                        cmd.copy = 1'b1;
                        cmd.oidx = idx;
                    end else begin
                        // startup ticks
                        has_result = 1'b0;
                    end
                end
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

    assign push = accept && has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cd_reg   <= 8'd0;
            page_reg <= 8'd0;
            src_reg  <= 16'd0;
        end else if (accept) begin
            cd_reg   <= cd_next;
            page_reg <= page_next;
            src_reg  <= src_next;
        end
    end

endmodule

>>> rtl/core/bdo_queue.sv
module bdo_queue
    import bdo_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/bdo_back.sv
module bdo_back
    import bdo_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  cmd_t        q_data,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_target,
    output logic [15:0] m_offset,
    output logic        m_write_enable,
    output logic [7:0]  m_store_byte,
    output logic        m_direct_valid,
    output logic [7:0]  m_direct_byte,
    output logic        m_dma_copy,
    output logic [7:0]  m_oam_index
);

    cmd_t res;
    logic load;
    logic [15:0] a;

    logic        valid_reg;
    target_t     target_reg;
    logic [15:0] offset_reg;
    logic        we_reg;
    logic [7:0]  sbyte_reg;
    logic        dvalid_reg;
    logic [7:0]  dbyte_reg;
    logic        copy_reg;
    logic [7:0]  oidx_reg;

    assign a = q_data.addr;

    // plain memory read decode
    always_comb begin
        res = q_data;
        if (q_data.raw) begin
            res.target = T_NONE;
            res.addr   = 16'd0;
            res.dvalid = 1'b0;
            res.dbyte  = 8'd0;
            if (a >= ADDR_ECHO) begin
                res.target = T_ECHO;
                res.addr   = a - ADDR_ECHO;
            end else if (a >= ADDR_WRAM1) begin
                res.target = T_WRAM1;
                res.addr   = a - ADDR_WRAM1;
            end else if (a >= ADDR_WRAM0) begin
                res.target = T_WRAM0;
                res.addr   = a - ADDR_WRAM0;
            end else if (a >= ADDR_VRAM && a < ADDR_XRAM) begin
                res.target = T_VRAM;
                res.addr   = a - ADDR_VRAM;
            end else if (a < ADDR_BOOTEND && cfg.boot_rom_mapped) begin
                res.target = T_BOOT;
                res.addr   = a;
            end else if (cfg.cartridge_present) begin
                res.target = T_CART;
                res.addr   = a;
            end else begin
                res.dvalid = 1'b1;
                res.dbyte  = OPEN_BUS;
            end
        end
    end

    assign load  = q_valid && (!valid_reg || m_ready);
    assign q_pop = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            target_reg <= res.target;
            offset_reg <= res.addr;
            we_reg     <= res.we;
            sbyte_reg  <= res.sbyte;
            dvalid_reg <= res.dvalid;
            dbyte_reg  <= res.dbyte;
            copy_reg   <= res.copy;
            oidx_reg   <= res.oidx;
        end
    end

    assign m_valid        = valid_reg;
    assign m_target       = target_reg;
    assign m_offset       = offset_reg;
    assign m_write_enable = we_reg;
    assign m_store_byte   = sbyte_reg;
    assign m_direct_valid = dvalid_reg;
    assign m_direct_byte  = dbyte_reg;
    assign m_dma_copy     = copy_reg;
    assign m_oam_index    = oidx_reg;

endmodule
